/* rtl/dmpid_pkg.sv */
// Shared widths, codes, types and clamp helpers for the dual-mode PID controller.
`default_nettype none
package dmpid_pkg;

	// Field and datapath widths.
	localparam int DATA_W      = 16;
	localparam int ERR_W       = 17;
	localparam int DE_W        = 18;
	localparam int D2E_W       = 19;
	localparam int GAIN_W      = 32;
	localparam int PROD_W      = 51;
	localparam int WIDE_W      = 56;
	localparam int STATE_W     = 34;
	localparam int DRIVE_W     = 33;
	localparam int CFG_W       = 32;
	localparam int IDX_W       = 3;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	// Output queue geometry.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int CNT_W      = FIFO_AW + 1;

	// One in Q16.16.
	localparam logic signed [WIDE_W-1:0] ONE_Q16 = WIDE_W'(65536);

	// Operation codes carried in the input tuser.
	localparam logic OP_STEP  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_MODE,
		REG_MAX_OUT,
		REG_INT_LIM,
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_CUTOFF,
		REG_DEAD_BAND
	} reg_idx_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK,
		ST_CUTOFF,
		ST_DEAD_BAND,
		ST_CLEARED
	} status_t;

	// Configuration bundle distributed to the datapath.
	typedef struct packed {
		logic                      mode;
		logic [15:0]               max_out;
		logic [15:0]               int_lim;
		logic signed [GAIN_W-1:0]  gain_p;
		logic signed [GAIN_W-1:0]  gain_i;
		logic signed [GAIN_W-1:0]  gain_d;
		logic [ERR_W-1:0]          cutoff;
		logic [ERR_W-1:0]          dead_band;
	} cfg_t;

	// Error terms leaving the front stage.
	typedef struct packed {
		logic                      valid;
		status_t                   status;
		logic signed [ERR_W-1:0]   e;
		logic signed [DE_W-1:0]    de;
		logic signed [D2E_W-1:0]   d2e;
	} front_t;

	// Gain products leaving the multiplier stage.
	typedef struct packed {
		logic                      valid;
		status_t                   status;
		logic signed [PROD_W-1:0]  pa;
		logic signed [PROD_W-1:0]  ib;
		logic signed [PROD_W-1:0]  dc;
	} prod_t;

	// One result item as stored in the output queue.
	typedef struct packed {
		status_t                   status;
		logic signed [DRIVE_W-1:0] drive;
	} result_t;

	// Symmetric clamp to plus or minus lim.
	function automatic logic signed [WIDE_W-1:0] clamp_sym(
		input logic signed [WIDE_W-1:0] v,
		input logic signed [WIDE_W-1:0] lim
	);
		if (v > lim) begin
			return lim;
		end else if (v < -lim) begin
			return -lim;
		end else begin
			return v;
		end
	endfunction

	// Integer-unit magnitude turned into a Q16.16 limit.
	function automatic logic signed [WIDE_W-1:0] lim_of(input logic [15:0] m);
		return signed'(WIDE_W'({m, 16'h0000}));
	endfunction

endpackage
`default_nettype wire

/* rtl/dmpid_front.sv */
// Input register, error forming, suppression checks and error history.
`default_nettype none
module dmpid_front (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_accept,
	input  wire                                in_op,
	input  wire logic signed [dmpid_pkg::DATA_W-1:0] in_setpoint,
	input  wire logic signed [dmpid_pkg::DATA_W-1:0] in_measured,
	input  wire dmpid_pkg::cfg_t               cfg,
	output dmpid_pkg::front_t                  front_s2
);

	logic                                   v_s1;
	logic                                   op_s1;
	logic signed [dmpid_pkg::DATA_W-1:0]    sp_s1;
	logic signed [dmpid_pkg::DATA_W-1:0]    ms_s1;
	logic signed [dmpid_pkg::ERR_W-1:0]     e1_q;
	logic signed [dmpid_pkg::ERR_W-1:0]     e2_q;
	logic signed [dmpid_pkg::ERR_W-1:0]     e_c;
	logic [dmpid_pkg::ERR_W-1:0]            mag_c;
	logic signed [dmpid_pkg::DE_W-1:0]      de_c;
	logic signed [dmpid_pkg::D2E_W-1:0]     d2e_c;
	dmpid_pkg::status_t                     status_c;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1 <= in_op;
			sp_s1 <= in_setpoint;
			ms_s1 <= in_measured;
		end
	end

	// Error, its magnitude and the first and second differences.
	assign e_c   = dmpid_pkg::ERR_W'(sp_s1) - dmpid_pkg::ERR_W'(ms_s1);
	assign mag_c = e_c[dmpid_pkg::ERR_W-1] ? dmpid_pkg::ERR_W'(-e_c) : dmpid_pkg::ERR_W'(e_c);
	assign de_c  = dmpid_pkg::DE_W'(e_c) - dmpid_pkg::DE_W'(e1_q);
	assign d2e_c = dmpid_pkg::D2E_W'(e_c) - (dmpid_pkg::D2E_W'(e1_q) <<< 1)
		+ dmpid_pkg::D2E_W'(e2_q);

	// Clear wins, then the cutoff check, then the dead band.
	always_comb begin
		if (op_s1 == dmpid_pkg::OP_CLEAR) begin
			status_c = dmpid_pkg::ST_CLEARED;
		end else if ((cfg.cutoff != '0) && (mag_c > cfg.cutoff)) begin
			status_c = dmpid_pkg::ST_CUTOFF;
		end else if ((cfg.dead_band != '0) && (mag_c < cfg.dead_band)) begin
			status_c = dmpid_pkg::ST_DEAD_BAND;
		end else begin
			status_c = dmpid_pkg::ST_OK;
		end
	end

	// Error history moves only on computed steps and is zeroed on clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q <= '0;
			e2_q <= '0;
		end else if (v_s1) begin
			if (status_c == dmpid_pkg::ST_CLEARED) begin
				e1_q <= '0;
				e2_q <= '0;
			end else if (status_c == dmpid_pkg::ST_OK) begin
				e2_q <= e1_q;
				e1_q <= e_c;
			end
		end
	end

	// Stage two register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s2 <= '0;
		end else begin
			front_s2.valid  <= v_s1;
			front_s2.status <= status_c;
			front_s2.e      <= e_c;
			front_s2.de     <= de_c;
			front_s2.d2e    <= d2e_c;
		end
	end

endmodule
`default_nettype wire

/* rtl/dmpid_mul.sv */
// Gain multiplier stage: three products of gains and error terms.
`default_nettype none
module dmpid_mul (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire dmpid_pkg::cfg_t  cfg,
	input  wire dmpid_pkg::front_t front_s2,
	output dmpid_pkg::prod_t      prod_s3
);

	logic signed [dmpid_pkg::D2E_W-1:0]  op_a;
	logic signed [dmpid_pkg::D2E_W-1:0]  op_c;
	logic signed [dmpid_pkg::PROD_W-1:0] pa_c;
	logic signed [dmpid_pkg::PROD_W-1:0] ib_c;
	logic signed [dmpid_pkg::PROD_W-1:0] dc_c;

	// Positional uses e and de; incremental uses de and d2e.
	assign op_a = cfg.mode ? dmpid_pkg::D2E_W'(front_s2.de) : dmpid_pkg::D2E_W'(front_s2.e);
	assign op_c = cfg.mode ? front_s2.d2e : dmpid_pkg::D2E_W'(front_s2.de);

	assign pa_c = dmpid_pkg::PROD_W'(cfg.gain_p) * dmpid_pkg::PROD_W'(op_a);
	assign ib_c = dmpid_pkg::PROD_W'(cfg.gain_i) * dmpid_pkg::PROD_W'(front_s2.e);
	assign dc_c = dmpid_pkg::PROD_W'(cfg.gain_d) * dmpid_pkg::PROD_W'(op_c);

	// Stage three register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s3 <= '0;
		end else begin
			prod_s3.valid  <= front_s2.valid;
			prod_s3.status <= front_s2.status;
			prod_s3.pa     <= pa_c;
			prod_s3.ib     <= ib_c;
			prod_s3.dc     <= dc_c;
		end
	end

endmodule
`default_nettype wire

/* rtl/dmpid_core.sv */
// Term sums, integral and held-output state, and the final output clamp.
`default_nettype none
module dmpid_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire dmpid_pkg::cfg_t  cfg,
	input  wire dmpid_pkg::prod_t prod_s3,
	output logic                  res_valid,
	output dmpid_pkg::result_t    res
);

	logic signed [dmpid_pkg::WIDE_W-1:0]  pd_c;
	logic signed [dmpid_pkg::WIDE_W-1:0]  delta_c;
	logic signed [dmpid_pkg::WIDE_W-1:0]  delta_eff_c;
	logic signed [dmpid_pkg::WIDE_W-1:0]  out_lim;
	logic signed [dmpid_pkg::WIDE_W-1:0]  acc_new;
	logic signed [dmpid_pkg::WIDE_W-1:0]  held_new;
	logic signed [dmpid_pkg::WIDE_W-1:0]  res_c;

	logic                                 v_s4;
	dmpid_pkg::status_t                   status_s4;
	logic signed [dmpid_pkg::PROD_W-1:0]  ib_s4;
	logic signed [dmpid_pkg::WIDE_W-1:0]  pd_s4;
	logic signed [dmpid_pkg::WIDE_W-1:0]  delta_s4;

	logic signed [dmpid_pkg::STATE_W-1:0] acc_q;
	logic signed [dmpid_pkg::STATE_W-1:0] held_q;

	logic                                 v_s5;
	dmpid_pkg::status_t                   status_s5;
	logic signed [dmpid_pkg::WIDE_W-1:0]  pd_s5;
	logic signed [dmpid_pkg::STATE_W-1:0] acc_s5;
	logic signed [dmpid_pkg::STATE_W-1:0] held_s5;

	assign out_lim = dmpid_pkg::lim_of(cfg.max_out);

	// Positional P plus D, and the incremental delta gated by its dead zone.
	assign pd_c    = dmpid_pkg::WIDE_W'(prod_s3.pa) + dmpid_pkg::WIDE_W'(prod_s3.dc);
	assign delta_c = pd_c + dmpid_pkg::WIDE_W'(prod_s3.ib);
	assign delta_eff_c = ((delta_c > dmpid_pkg::ONE_Q16) || (delta_c < -dmpid_pkg::ONE_Q16))
		? delta_c : '0;

	// Stage four register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= prod_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		status_s4 <= prod_s3.status;
		ib_s4     <= prod_s3.ib;
		pd_s4     <= pd_c;
		delta_s4  <= delta_eff_c;
	end

	// Next values of the two accumulators.
	assign acc_new  = dmpid_pkg::clamp_sym(
		dmpid_pkg::WIDE_W'(acc_q) + dmpid_pkg::WIDE_W'(ib_s4),
		dmpid_pkg::lim_of(cfg.int_lim));
	assign held_new = dmpid_pkg::clamp_sym(dmpid_pkg::WIDE_W'(held_q) + delta_s4, out_lim);

	// Controller state: each mode updates only its own accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
		end else if (v_s4) begin
			if (status_s4 == dmpid_pkg::ST_CLEARED) begin
				acc_q  <= '0;
				held_q <= '0;
			end else if (status_s4 == dmpid_pkg::ST_OK) begin
				if (cfg.mode) begin
					held_q <= dmpid_pkg::STATE_W'(held_new);
				end else begin
					acc_q <= dmpid_pkg::STATE_W'(acc_new);
				end
			end
		end
	end

	// Stage five register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		status_s5 <= status_s4;
		pd_s5     <= pd_s4;
		acc_s5    <= dmpid_pkg::STATE_W'(acc_new);
		held_s5   <= dmpid_pkg::STATE_W'(held_new);
	end

	// Final output selection and clamp; suppressed and cleared items drive zero.
	assign res_c = cfg.mode ? dmpid_pkg::WIDE_W'(held_s5)
		: dmpid_pkg::clamp_sym(pd_s5 + dmpid_pkg::WIDE_W'(acc_s5), out_lim);

	assign res_valid  = v_s5;
	assign res.status = status_s5;
	assign res.drive  = (status_s5 == dmpid_pkg::ST_OK) ? dmpid_pkg::DRIVE_W'(res_c) : '0;

endmodule
`default_nettype wire

/* rtl/dmpid_ofifo.sv */
// Output queue that holds finished results until the consumer takes them.
`default_nettype none
module dmpid_ofifo (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire dmpid_pkg::result_t  push_data,
	input  wire                      pop,
	output logic                     out_valid,
	output dmpid_pkg::result_t       out_data
);

	dmpid_pkg::result_t                mem_q [dmpid_pkg::FIFO_DEPTH];
	logic [dmpid_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [dmpid_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [dmpid_pkg::CNT_W-1:0]       count_q;

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + dmpid_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + dmpid_pkg::FIFO_AW'(1);
			end
			count_q <= count_q + dmpid_pkg::CNT_W'(push) - dmpid_pkg::CNT_W'(pop);
		end
	end

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

/* rtl/dual_mode_pid_controller.sv */
// Top level of the dual-mode PID controller: config registers, pipeline and output queue.
//
// Channel   Direction  Request contents
// s_*       in         tuser: operation; tdata: setpoint [15:0], measured [31:16]
// m_*       out        tuser: status; tdata: drive [32:0], zero fill [39:33]
// cfg_*     in         register index and write data, taken on every cycle cfg_wen is high
//
// One request is accepted per cycle while s_tready is high. Five pipeline registers (the
// first loaded at the accepting edge) and the queue write lie between acceptance of a
// request and its result appearing on m_tvalid.
// s_tready drops only when eight requests are accepted and not yet taken, so a stalled
// consumer holds the input side.
// arst_n clears the error history, integral and held output to zero and loads the
// register reset values; no clearing pass is needed.
`default_nettype none
module dual_mode_pid_controller (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// Input requests.
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire [dmpid_pkg::IN_TDATA_W-1:0]      s_tdata,   // setpoint, measured
	input  wire                                  s_tuser,   // operation
	// Results.
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [dmpid_pkg::OUT_TDATA_W-1:0]    m_tdata,   // drive, zero fill
	output logic [1:0]                           m_tuser,   // status
	// Configuration writes.
	input  wire                                  cfg_wen,
	input  wire [dmpid_pkg::IDX_W-1:0]           cfg_index,
	input  wire [dmpid_pkg::CFG_W-1:0]           cfg_data
);

	dmpid_pkg::cfg_t             cfg_q;
	dmpid_pkg::front_t           front_s2;
	dmpid_pkg::prod_t            prod_s3;
	dmpid_pkg::result_t          res;
	dmpid_pkg::result_t          fifo_out;
	logic                        res_valid;
	logic                        in_accept;
	logic                        out_accept;
	logic [dmpid_pkg::CNT_W-1:0] inflight_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= 1'b0;
			cfg_q.max_out   <= 16'hFFFF;
			cfg_q.int_lim   <= 16'hFFFF;
			cfg_q.gain_p    <= '0;
			cfg_q.gain_i    <= '0;
			cfg_q.gain_d    <= '0;
			cfg_q.cutoff    <= '0;
			cfg_q.dead_band <= '0;
		end else if (cfg_wen) begin
			case (dmpid_pkg::reg_idx_t'(cfg_index))
				dmpid_pkg::REG_MODE:      cfg_q.mode      <= cfg_data[0];
				dmpid_pkg::REG_MAX_OUT:   cfg_q.max_out   <= cfg_data[15:0];
				dmpid_pkg::REG_INT_LIM:   cfg_q.int_lim   <= cfg_data[15:0];
				dmpid_pkg::REG_GAIN_P:    cfg_q.gain_p    <= signed'(cfg_data);
				dmpid_pkg::REG_GAIN_I:    cfg_q.gain_i    <= signed'(cfg_data);
				dmpid_pkg::REG_GAIN_D:    cfg_q.gain_d    <= signed'(cfg_data);
				dmpid_pkg::REG_CUTOFF:    cfg_q.cutoff    <= cfg_data[dmpid_pkg::ERR_W-1:0];
				dmpid_pkg::REG_DEAD_BAND: cfg_q.dead_band <= cfg_data[dmpid_pkg::ERR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Handshakes; input readiness comes from the count of outstanding requests.
	assign s_tready   = (inflight_q != dmpid_pkg::CNT_W'(dmpid_pkg::FIFO_DEPTH));
	assign in_accept  = s_tvalid && s_tready;
	assign out_accept = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + dmpid_pkg::CNT_W'(in_accept)
				- dmpid_pkg::CNT_W'(out_accept);
		end
	end

	// Datapath.
	dmpid_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_accept   (in_accept),
		.in_op       (s_tuser),
		.in_setpoint (signed'(s_tdata[15:0])),
		.in_measured (signed'(s_tdata[31:16])),
		.cfg         (cfg_q),
		.front_s2    (front_s2)
	);

	dmpid_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.front_s2 (front_s2),
		.prod_s3  (prod_s3)
	);

	dmpid_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.prod_s3   (prod_s3),
		.res_valid (res_valid),
		.res       (res)
	);

	dmpid_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (out_accept),
		.out_valid (m_tvalid),
		.out_data  (fifo_out)
	);

	// Result packing.
	assign m_tuser = fifo_out.status;
	assign m_tdata = {{(dmpid_pkg::OUT_TDATA_W - dmpid_pkg::DRIVE_W){1'b0}}, fifo_out.drive};

`ifndef SYNTH
	// Outstanding requests never exceed the queue depth.
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= dmpid_pkg::CNT_W'(dmpid_pkg::FIFO_DEPTH))
		else $error("outstanding request count exceeds queue depth");

	// A finished result always belongs to an outstanding request.
	a_result_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (inflight_q != '0))
		else $error("pipeline produced a result with no outstanding request");

	// Suppressed and cleared results carry a zero drive.
	a_zero_when_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != dmpid_pkg::ST_OK)) |-> (m_tdata == '0))
		else $error("nonzero drive on a suppressed or cleared result");
`endif

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking stream testbench for the dual-mode PID controller, with its own step predictor.
module testbench;

	localparam int     CYCLE_LIMIT   = 1_000_000;
	localparam int     RANDOM_PHASES = 14;
	localparam int     PHASE_ITEMS   = 102;
	localparam longint Q16_ONE       = 64'sd65536;

	// One control request as the driver sees it.
	typedef struct {
		logic               op;
		logic signed [15:0] setpoint;
		logic signed [15:0] measured;
	} pid_request_t;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              s_tvalid  = 1'b0;
	logic                              s_tready;
	logic [dmpid_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;   // setpoint, measured
	logic                              s_tuser   = dmpid_pkg::OP_STEP;   // operation
	logic                              m_tvalid;
	logic                              m_tready  = 1'b0;
	logic [dmpid_pkg::OUT_TDATA_W-1:0] m_tdata;          // drive, zero fill
	logic [1:0]                        m_tuser;          // status
	logic                              cfg_wen   = 1'b0;
	dmpid_pkg::reg_idx_t               cfg_index = dmpid_pkg::REG_MODE;
	logic [dmpid_pkg::CFG_W-1:0]       cfg_data  = '0;

	// Predictor copy of the registers.
	bit     cfg_incremental = 1'b0;
	longint cfg_max_out     = 65535;
	longint cfg_int_lim     = 65535;
	longint cfg_gain_p      = 0;
	longint cfg_gain_i      = 0;
	longint cfg_gain_d      = 0;
	longint cfg_cutoff      = 0;
	longint cfg_dead_band   = 0;

	// Predictor copy of the controller state.
	longint err_last   = 0;
	longint err_before = 0;
	longint integ_q16  = 0;
	longint held_q16   = 0;

	pid_request_t       request_q[$];
	dmpid_pkg::result_t drive_expect_q[$];
	pid_request_t       tx_next;
	pid_request_t       tx_seen;
	dmpid_pkg::result_t rx_want;
	int                 tx_gap      = 0;
	int                 rx_stall    = 0;
	int                 rx_hold;
	int                 sent_count  = 0;
	int                 taken_count = 0;
	int                 mismatches  = 0;
	int                 cycle_count = 0;
	bit                 tx_idle_on  = 1'b0;
	bit                 rx_stall_on = 1'b0;

	dual_mode_pid_controller i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim) begin
			return lim;
		end else if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	// Computes the result of one accepted request and advances the predicted state.
	function automatic dmpid_pkg::result_t pid_step(pid_request_t rq);
		longint             sp;
		longint             mv;
		longint             err;
		longint             mag;
		longint             out_lim;
		longint             delta;
		longint             res;
		dmpid_pkg::result_t r;
		sp      = rq.setpoint;
		mv      = rq.measured;
		out_lim = cfg_max_out * Q16_ONE;
		r.drive = '0;
		if (rq.op == dmpid_pkg::OP_CLEAR) begin
			err_last   = 0;
			err_before = 0;
			integ_q16  = 0;
			held_q16   = 0;
			r.status   = dmpid_pkg::ST_CLEARED;
			return r;
		end
		err = sp - mv;
		mag = (err < 0) ? -err : err;
		// The cutoff test takes priority over the dead band; neither touches the state.
		if (cfg_cutoff != 0 && mag > cfg_cutoff) begin
			r.status = dmpid_pkg::ST_CUTOFF;
			return r;
		end
		if (cfg_dead_band != 0 && mag < cfg_dead_band) begin
			r.status = dmpid_pkg::ST_DEAD_BAND;
			return r;
		end
		if (!cfg_incremental) begin
			integ_q16 = clamp_mag(integ_q16 + cfg_gain_i * err, cfg_int_lim * Q16_ONE);
			res = clamp_mag(cfg_gain_p * err + integ_q16 + cfg_gain_d * (err - err_last),
				out_lim);
		end else begin
			delta = cfg_gain_p * (err - err_last) + cfg_gain_i * err
				+ cfg_gain_d * (err - 2 * err_last + err_before);
			// A step of one unit or less is dropped, but the clamp still applies.
			if (delta > Q16_ONE || delta < -Q16_ONE) begin
				held_q16 = held_q16 + delta;
			end
			held_q16 = clamp_mag(held_q16, out_lim);
			res      = held_q16;
		end
		err_before = err_last;
		err_last   = err;
		r.status   = dmpid_pkg::ST_OK;
		r.drive    = res[dmpid_pkg::DRIVE_W-1:0];
		return r;
	endfunction

	function automatic void set_register(dmpid_pkg::reg_idx_t idx, logic [31:0] val);
		case (idx)
			dmpid_pkg::REG_MODE:      cfg_incremental = val[0];
			dmpid_pkg::REG_MAX_OUT:   cfg_max_out     = val[15:0];
			dmpid_pkg::REG_INT_LIM:   cfg_int_lim     = val[15:0];
			dmpid_pkg::REG_GAIN_P:    cfg_gain_p      = signed'(val);
			dmpid_pkg::REG_GAIN_I:    cfg_gain_i      = signed'(val);
			dmpid_pkg::REG_GAIN_D:    cfg_gain_d      = signed'(val);
			dmpid_pkg::REG_CUTOFF:    cfg_cutoff      = val[16:0];
			dmpid_pkg::REG_DEAD_BAND: cfg_dead_band   = val[16:0];
			default: ;
		endcase
	endfunction

	// Mostly short gaps, a few long ones, none when idling is switched off.
	function automatic int idle_len(bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 55) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] rand_gain();
		int mag;
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			1: return '0;
			2: return $urandom();
			default: begin
				mag = $urandom_range(0, 1 << $urandom_range(4, 20));
				return $urandom_range(0, 1) ? -mag : mag;
			end
		endcase
	endfunction

	function automatic logic [31:0] rand_limit16();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 65535;
			default: return $urandom_range(1, 65535) >> $urandom_range(0, 14);
		endcase
	endfunction

	function automatic void queue_request(logic op, int sp, int mv);
		pid_request_t rq;
		rq.op       = op;
		rq.setpoint = sp[15:0];
		rq.measured = mv[15:0];
		request_q.push_back(rq);
		sent_count++;
	endfunction

	// Random request: close pairs for fine control, full-range pairs and range extremes.
	function automatic void queue_random_request();
		int sp;
		int mv;
		int diff;
		logic op;
		op = ($urandom_range(0, 39) == 0) ? dmpid_pkg::OP_CLEAR : dmpid_pkg::OP_STEP;
		sp = int'($urandom_range(0, 65535)) - 32768;
		case ($urandom_range(0, 9))
			0, 1, 2: mv = int'($urandom_range(0, 65535)) - 32768;
			3: begin
				sp = $urandom_range(0, 1) ? 32767 : -32768;
				mv = $urandom_range(0, 1) ? 32767 : -32768;
			end
			default: begin
				diff = $urandom_range(0, 1 << $urandom_range(0, 12));
				mv   = $urandom_range(0, 1) ? sp - diff : sp + diff;
				if (mv > 32767) begin
					mv = 32767;
				end else if (mv < -32768) begin
					mv = -32768;
				end
			end
		endcase
		queue_request(op, sp, mv);
	endfunction

	task automatic write_reg(dmpid_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		set_register(idx, val);
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Blocks until every queued request is taken and every result has come back.
	task automatic wait_for_drain();
		while (taken_count != sent_count || drive_expect_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Loads a fresh register setting; the first two phases use the extremes.
	task automatic randomize_config(int ph);
		logic [31:0] mode;
		logic [31:0] max_out;
		logic [31:0] int_lim;
		logic [31:0] cutoff;
		logic [31:0] dead;
		mode    = (ph == 0) ? 1 : (ph == 1) ? 0 : $urandom_range(0, 1);
		max_out = (ph == 0) ? 65535 : (ph == 1) ? 0 : rand_limit16();
		int_lim = (ph == 0) ? 65535 : (ph == 1) ? 0 : rand_limit16();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: cutoff = 0;
			5: cutoff = 131071;
			default: cutoff = $urandom_range(1, 1 << $urandom_range(1, 16));
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: dead = 0;
			default: dead = $urandom_range(1, 1 << $urandom_range(1, 10));
		endcase
		if (ph == 0) begin
			cutoff = 131071;
			dead   = 1;
		end else if (ph == 1) begin
			cutoff = 0;
			dead   = 0;
		end else if (ph == 2) begin
			dead = 131071;
		end
		write_reg(dmpid_pkg::REG_MODE, mode);
		write_reg(dmpid_pkg::REG_MAX_OUT, max_out);
		write_reg(dmpid_pkg::REG_INT_LIM, int_lim);
		write_reg(dmpid_pkg::REG_GAIN_P,
			(ph == 0) ? 32'h7fff_ffff : (ph == 1) ? 32'h8000_0000 : rand_gain());
		write_reg(dmpid_pkg::REG_GAIN_I,
			(ph == 0) ? 32'h7fff_ffff : (ph == 1) ? 32'h8000_0000 : rand_gain());
		write_reg(dmpid_pkg::REG_GAIN_D,
			(ph == 0) ? 32'h7fff_ffff : (ph == 1) ? 32'h8000_0000 : rand_gain());
		write_reg(dmpid_pkg::REG_CUTOFF, cutoff);
		write_reg(dmpid_pkg::REG_DEAD_BAND, dead);
		end_writes();
	endtask

	// Request driver: presents queued requests with random gaps and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= dmpid_pkg::OP_STEP;
			tx_gap   <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				tx_seen.op       = s_tuser;
				tx_seen.setpoint = s_tdata[15:0];
				tx_seen.measured = s_tdata[31:16];
				drive_expect_q.push_back(pid_step(tx_seen));
				taken_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					tx_gap   <= tx_gap - 1;
					s_tvalid <= 1'b0;
				end else if (request_q.size() != 0) begin
					tx_next   = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= tx_next.op;
					s_tdata  <= {tx_next.measured, tx_next.setpoint};
					tx_gap   <= idle_len(tx_idle_on);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each accepted result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (drive_expect_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, drive %0d status %0d", $time,
						$signed(m_tdata[dmpid_pkg::DRIVE_W-1:0]), m_tuser);
				end else begin
					rx_want = drive_expect_q.pop_front();
					if (m_tdata !== {{(dmpid_pkg::OUT_TDATA_W - dmpid_pkg::DRIVE_W){1'b0}},
						rx_want.drive}) begin
						mismatches++;
						$display("%0t: drive expected %0d, got %0d (tdata %h)", $time,
							$signed(rx_want.drive),
							$signed(m_tdata[dmpid_pkg::DRIVE_W-1:0]), m_tdata);
					end
					if (m_tuser !== rx_want.status) begin
						mismatches++;
						$display("%0t: status expected %0d, got %0d", $time,
							rx_want.status, m_tuser);
					end
				end
			end
			if (rx_stall != 0) begin
				rx_stall <= rx_stall - 1;
				m_tready <= 1'b0;
			end else begin
				rx_hold = idle_len(rx_stall_on);
				rx_stall <= rx_hold;
				m_tready <= (rx_hold == 0);
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("dual_mode_pid_controller: mismatch");
			$finish;
		end
	end

	// Stimulus sequence: directed cases first, then randomized phases.
	initial begin
		int ph;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Positional mode: integral and output clamps, full-scale errors, clear.
		write_reg(dmpid_pkg::REG_MAX_OUT, 100);
		write_reg(dmpid_pkg::REG_INT_LIM, 50);
		write_reg(dmpid_pkg::REG_GAIN_P, 32'h0001_0000);
		write_reg(dmpid_pkg::REG_GAIN_I, 32'h0000_8000);
		write_reg(dmpid_pkg::REG_GAIN_D, 32'hffff_0000);
		end_writes();
		queue_request(dmpid_pkg::OP_STEP, 0, 0);
		queue_request(dmpid_pkg::OP_STEP, 5, 2);
		queue_request(dmpid_pkg::OP_STEP, 7, 2);
		queue_request(dmpid_pkg::OP_STEP, 32767, -32768);
		queue_request(dmpid_pkg::OP_STEP, -32768, 32767);
		queue_request(dmpid_pkg::OP_CLEAR, 0, 0);
		queue_request(dmpid_pkg::OP_STEP, 1, 0);
		wait_for_drain();

		// Cutoff and dead band on both sides of their thresholds.
		tx_idle_on  = 1'b1;
		rx_stall_on = 1'b1;
		write_reg(dmpid_pkg::REG_CUTOFF, 1000);
		write_reg(dmpid_pkg::REG_DEAD_BAND, 10);
		end_writes();
		queue_request(dmpid_pkg::OP_STEP, 1001, 0);
		queue_request(dmpid_pkg::OP_STEP, 0, 1001);
		queue_request(dmpid_pkg::OP_STEP, 1000, 0);
		queue_request(dmpid_pkg::OP_STEP, -5, 4);
		queue_request(dmpid_pkg::OP_STEP, 10, 0);
		queue_request(dmpid_pkg::OP_STEP, 3, 3);
		wait_for_drain();

		// Incremental mode: steps below, at and above one unit.
		write_reg(dmpid_pkg::REG_MODE, 1);
		write_reg(dmpid_pkg::REG_MAX_OUT, 65535);
		write_reg(dmpid_pkg::REG_GAIN_P, 32'h0000_8000);
		write_reg(dmpid_pkg::REG_GAIN_I, 32'h0000_0000);
		write_reg(dmpid_pkg::REG_GAIN_D, 32'h0000_0000);
		write_reg(dmpid_pkg::REG_CUTOFF, 0);
		write_reg(dmpid_pkg::REG_DEAD_BAND, 0);
		end_writes();
		queue_request(dmpid_pkg::OP_CLEAR, 0, 0);
		queue_request(dmpid_pkg::OP_STEP, 1, 0);
		queue_request(dmpid_pkg::OP_STEP, 3, 0);
		queue_request(dmpid_pkg::OP_STEP, 6, 0);
		queue_request(dmpid_pkg::OP_STEP, 4, 0);
		queue_request(dmpid_pkg::OP_STEP, 0, 2);
		wait_for_drain();

		// A zero output limit still clamps the held output when the step is dropped.
		write_reg(dmpid_pkg::REG_MAX_OUT, 0);
		end_writes();
		queue_request(dmpid_pkg::OP_STEP, 0, 0);
		queue_request(dmpid_pkg::OP_STEP, 2, 0);
		queue_request(dmpid_pkg::OP_CLEAR, 0, 0);
		wait_for_drain();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			randomize_config(ph);
			tx_idle_on  = (ph % 4 != 3);
			rx_stall_on = (ph % 3 != 2);
			repeat (PHASE_ITEMS) queue_random_request();
			wait_for_drain();
		end

		repeat (16) @(posedge clk);
		if (mismatches == 0 && drive_expect_q.size() == 0) begin
			$display("dual_mode_pid_controller: match");
		end else begin
			$display("dual_mode_pid_controller: mismatch");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/dmpid_pkg.sv
rtl/dmpid_front.sv
rtl/dmpid_mul.sv
rtl/dmpid_core.sv
rtl/dmpid_ofifo.sv
rtl/dual_mode_pid_controller.sv
tb/sv/testbench.sv
